/* design/assert_macros.svh */
// Assertion helpers shared by the serializer modules.
// Every module that uses them has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define I2CDW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("i2cdw check failed");

// When the trigger holds, the consequence must hold at the next clock edge.
`define I2CDW_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("i2cdw check failed");

`endif

/* design/i2cdw_pkg.sv */
package i2cdw_pkg;

  // Opcode values on the input tuser field.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_CMD_CTRL = 2'd1;
  localparam logic [1:0] CFG_DAT_CTRL = 2'd2;

  localparam logic [7:0] DEV_ADDR_RST = 8'h78;
  localparam logic [7:0] CMD_CTRL_RST = 8'h00;
  localparam logic [7:0] DAT_CTRL_RST = 8'h40;

  // Transaction timeline, in ticks.
  localparam logic [6:0] START_LAST = 7'd3;
  localparam logic [6:0] STOP_BASE  = 7'd85;
  localparam logic [6:0] STOP_MID   = 7'd86;
  localparam logic [6:0] LAST_TICK  = 7'd87;

  // Offsets inside one byte slot.
  localparam logic [4:0] OFF_LAST_BIT = 5'd24;
  localparam logic [4:0] OFF_ACK_HIGH = 5'd25;
  localparam logic [4:0] OFF_LAST     = 5'd26;

  localparam logic [1:0] BYTE_ADDR = 2'd0;
  localparam logic [1:0] BYTE_CTRL = 2'd1;

  localparam logic [1:0] STEP_SDA  = 2'd0;
  localparam logic [1:0] STEP_HIGH = 2'd1;
  localparam logic [1:0] STEP_LOW  = 2'd2;

  // One classified tick as it travels from the front end to the engine.
  typedef struct packed {
    logic       req;
    logic       is_data;
    logic [7:0] payload;
  } tick_t;

  typedef struct packed {
    logic done;
    logic rejected;
    logic busy;
    logic sda;
    logic scl;
  } result_t;

endpackage

/* design/i2cdw_front.sv */
module i2cdw_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] payload
  input  logic [1:0]          s_axis_tuser,   // [1:0] opcode
  input  logic                q_full_i,
  output logic                push_o,
  output i2cdw_pkg::tick_t    tick_o
);

  always_comb begin
    tick_o.payload = s_axis_tdata;
    case (s_axis_tuser)
      i2cdw_pkg::OP_CMD: begin
        tick_o.req     = 1'b1;
        tick_o.is_data = 1'b0;
      end
      i2cdw_pkg::OP_DATA: begin
        tick_o.req     = 1'b1;
        tick_o.is_data = 1'b1;
      end
      default: begin
        // A plain tick, and the unused opcode, only advance the pins.
        tick_o.req     = 1'b0;
        tick_o.is_data = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

endmodule

/* design/i2cdw_queue.sv */
`include "assert_macros.svh"

module i2cdw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cdw_pkg::tick_t tick_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output i2cdw_pkg::tick_t tick_o
);

  i2cdw_pkg::tick_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tick_i;
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign tick_o  = mem_q[rd_ptr_q];

  `I2CDW_ASSERT(a_no_overflow, !(push_i && full_o))
  `I2CDW_ASSERT(a_no_underflow, !(pop_i && !valid_o))
  `I2CDW_ASSERT(a_ptrs_track_count,
                (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))

endmodule

/* design/i2cdw_back.sv */
`include "assert_macros.svh"

module i2cdw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               q_valid_i,
  input  i2cdw_pkg::tick_t   q_tick_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2cdw_pkg::result_t out_res_o
);

  logic [7:0] dev_addr_q, cmd_ctrl_q, dat_ctrl_q;

  logic [6:0] phase_q, phase_d;
  logic [4:0] off_q, off_d;
  logic [1:0] which_q, which_d;
  logic [1:0] step_q, step_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] held_q, held_d;
  logic       is_data_q, is_data_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       rej_d, done_d;

  logic               out_valid_q, out_valid_d;
  i2cdw_pkg::result_t res_q, res_d;

  logic fire;

  // A tick runs whenever the result slot is empty or is being drained.
  assign fire    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= i2cdw_pkg::DEV_ADDR_RST;
      cmd_ctrl_q <= i2cdw_pkg::CMD_CTRL_RST;
      dat_ctrl_q <= i2cdw_pkg::DAT_CTRL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        i2cdw_pkg::CFG_DEV_ADDR: dev_addr_q <= cfg_data_i;
        i2cdw_pkg::CFG_CMD_CTRL: cmd_ctrl_q <= cfg_data_i;
        i2cdw_pkg::CFG_DAT_CTRL: dat_ctrl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    off_d     = off_q;
    which_d   = which_q;
    step_d    = step_q;
    shift_d   = shift_q;
    held_d    = held_q;
    is_data_d = is_data_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rej_d     = 1'b0;
    done_d    = 1'b0;

    if (fire) begin
      if (phase_q == 7'd0) begin
        if (q_tick_i.req) begin
          held_d    = q_tick_i.payload;
          is_data_d = q_tick_i.is_data;
          scl_d     = 1'b1;
          phase_d   = 7'd1;
          off_d     = 5'd0;
          which_d   = 2'd0;
          step_d    = i2cdw_pkg::STEP_SDA;
        end
      end else begin
        rej_d = q_tick_i.req;
        if (phase_q <= i2cdw_pkg::START_LAST) begin
          // Start: SDA high, SDA low, SCL low.
          case (phase_q[1:0])
            2'd1:    sda_d = 1'b1;
            2'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
        end else if (phase_q < i2cdw_pkg::STOP_BASE) begin
          if (off_q == 5'd0) begin
            scl_d = 1'b0;
            case (which_q)
              i2cdw_pkg::BYTE_ADDR: shift_d = dev_addr_q;
              i2cdw_pkg::BYTE_CTRL: shift_d = is_data_q ? dat_ctrl_q : cmd_ctrl_q;
              default:              shift_d = held_q;
            endcase
            step_d = i2cdw_pkg::STEP_SDA;
          end else if (off_q <= i2cdw_pkg::OFF_LAST_BIT) begin
            case (step_q)
              i2cdw_pkg::STEP_SDA: begin
                sda_d   = shift_q[7];
                shift_d = {shift_q[6:0], 1'b0};
              end
              i2cdw_pkg::STEP_HIGH: scl_d = 1'b1;
              default:              scl_d = 1'b0;
            endcase
            step_d = (step_q == i2cdw_pkg::STEP_LOW) ? i2cdw_pkg::STEP_SDA
                                                     : step_q + 2'd1;
          end else if (off_q == i2cdw_pkg::OFF_ACK_HIGH) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
          if (off_q == i2cdw_pkg::OFF_LAST) begin
            off_d   = 5'd0;
            which_d = which_q + 2'd1;
          end else begin
            off_d = off_q + 5'd1;
          end
        end else if (phase_q == i2cdw_pkg::STOP_BASE) begin
          scl_d = 1'b1;
        end else if (phase_q == i2cdw_pkg::STOP_MID) begin
          sda_d = 1'b0;
        end else begin
          sda_d = 1'b1;
        end

        if (phase_q == i2cdw_pkg::LAST_TICK) begin
          phase_d = 7'd0;
          done_d  = 1'b1;
        end else begin
          phase_d = phase_q + 7'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (fire) begin
      out_valid_d    = 1'b1;
      res_d.scl      = scl_d;
      res_d.sda      = sda_d;
      res_d.busy     = phase_d != 7'd0;
      res_d.rejected = rej_d;
      res_d.done     = done_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 7'd0;
      off_q       <= 5'd0;
      which_q     <= 2'd0;
      step_q      <= i2cdw_pkg::STEP_SDA;
      is_data_q   <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      off_q       <= off_d;
      which_q     <= which_d;
      step_q      <= step_d;
      is_data_q   <= is_data_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    held_q  <= held_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  `I2CDW_ASSERT(a_phase_range, phase_q <= i2cdw_pkg::LAST_TICK)
  `I2CDW_ASSERT(a_off_range, off_q <= i2cdw_pkg::OFF_LAST)
  `I2CDW_ASSERT_NEXT(a_done_ends_busy, fire && phase_q == i2cdw_pkg::LAST_TICK,
                     phase_q == 7'd0 && res_q.done && !res_q.busy)
  `I2CDW_ASSERT_NEXT(a_stop_on_byte_end, fire && phase_q == i2cdw_pkg::STOP_BASE,
                     which_q == 2'd3 && off_q == 5'd0)

endmodule

/* design/i2c_display_write_serializer.sv */
// Write-only bit-banged I2C master for a display controller. Every transfer on the
// input stream is one pin tick and yields exactly one output transfer holding the SCL
// and SDA levels after that tick plus busy, rejected and done flags. A tick with
// opcode 1 (command) or 2 (data) while idle starts an 88-tick transaction: start,
// address byte, control byte, payload byte, each followed by an ack clock, then stop;
// requests that arrive while busy are dropped and flagged. The block takes one tick
// per clock cycle while neither side stalls: a decoder accepts ticks into a two-entry
// queue, and a counter-driven engine runs one queued tick per cycle into an output
// register, so each side can stall on its own. Ticks pass through the queue, then the
// output register. Registers (index: 0 device address, 1 command control byte, 2 data
// control byte) are written through the configuration channel, which is always ready.
module i2c_display_write_serializer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] payload
  input  logic [1:0] s_axis_tuser,   // [1:0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                     // [3] rejected, [4] done_res, [7:5] zero
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  i2cdw_pkg::tick_t   in_tick;
  i2cdw_pkg::tick_t   q_tick;
  i2cdw_pkg::result_t res;

  i2cdw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .tick_o        (in_tick)
  );

  i2cdw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tick_i  (in_tick),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .tick_o  (q_tick)
  );

  i2cdw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_tick_i    (q_tick),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, res};

endmodule
